>>> hdl/rgb_conv3x3_clamp_top_defines.svh
// ----------------------------------------------------------------------------
// rgb_conv3x3_clamp_top_defines.svh
// Assertion macros shared by the convolution block; define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef RGB_CONV3X3_CLAMP_TOP_DEFINES_SVH
`define RGB_CONV3X3_CLAMP_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property checked at every rising clock edge outside reset.
`define RCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define RCC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define RCC_ASSERT(lbl, prop, msg)
`define RCC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> hdl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg
// Types and constants of the 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = 8;
  localparam int TAPS      = 3;
  localparam int NTAP      = TAPS * TAPS;
  localparam int CLAMP_TOP = 255;
  localparam int CHAN_W    = 8;
  localparam int NCHAN     = 3;
  localparam int PIX_W     = NCHAN * CHAN_W;
  localparam int LINE_W    = 2 * PIX_W;

  localparam int WID_W     = 11;
  localparam int HGT_W     = 16;
  localparam int ROW_W     = HGT_W + 1;
  localparam int KROW_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int KX_W      = TAPS * COEF_BITS;

  // widest usable line length given the register width
  localparam int W_CAP = (MAX_WIDTH < (1 << WID_W)) ? MAX_WIDTH : (1 << WID_W) - 1;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = ((COL_W > WID_W) ? COL_W : WID_W) + 1;

  localparam int PROD_W   = CHAN_W + 1 + COEF_BITS;
  localparam int ROWSUM_W = PROD_W + 2;
  localparam int SUM_W    = PROD_W + 4;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_ABOVE  = 3'd2,
    REG_KERNEL_CENTER = 3'd3,
    REG_KERNEL_BELOW  = 3'd4
  } cfg_reg_e;

  typedef logic [TAPS-1:0][KROW_W-1:0] kern_t;

  // neighbourhood with out-of-image taps already zeroed, index r*TAPS+c
  typedef struct packed {
    logic [NTAP-1:0][PIX_W-1:0] px;
    logic                       last;
  } win_t;

  typedef struct packed {
    logic reserve;
    logic push;
  } fq_ctl_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } res_t;

endpackage

>>> hdl/rgb_conv3x3_clamp_top.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_clamp_top
// Zero-padded 3x3 convolution of a raster RGB stream, clamped to 0..255.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an item transfers on a rising edge with push high and full
//   low. kind_i = 0 carries a pixel, kind_i = 1 is a drain item. Send the
//   frame in raster order, then image_width + 1 drain items.
//   Result channel: while empty is low the oldest result is on the out ports;
//   it transfers on a rising edge with pop high.
//   Output pixel j is produced by input item j + image_width + 1 and passes
//   through the line store read, window, window queue, multiply, row sums,
//   and final add and clamp into the result queue.
//   Throughput is one item per cycle while full is low, set by the two-port
//   line store and the fully pipelined multiply-add per channel.
//   When the receiver stalls, results pile up in a 4-entry result queue, then
//   in a 4-entry window queue; full rises once the window queue is reserved
//   out, and non-producing items keep flowing until then.
//   Reset: 640x480, kernel copying the left neighbour, positions at frame
//   start. Line store is not cleared; unwritten words only reach masked taps.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   and must only change while no results are pending.
// ----------------------------------------------------------------------------
module rgb_conv3x3_clamp_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [rcc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcc_pkg::KROW_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                          push,
  output logic                          full,
  input  logic                          kind_i,
  input  logic [rcc_pkg::CHAN_W-1:0]    pixel_red_i,
  input  logic [rcc_pkg::CHAN_W-1:0]    pixel_green_i,
  input  logic [rcc_pkg::CHAN_W-1:0]    pixel_blue_i,
  // result channel
  output logic                          empty,
  input  logic                          pop,
  output logic [rcc_pkg::CHAN_W-1:0]    out_red_o,
  output logic [rcc_pkg::CHAN_W-1:0]    out_green_o,
  output logic [rcc_pkg::CHAN_W-1:0]    out_blue_o,
  output logic                          frame_end_o
);
  import rcc_pkg::*;

  // configuration registers
  logic [WID_W-1:0] image_width_q;
  logic [HGT_W-1:0] image_height_q;
  kern_t            kernel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WID_W'(640);
      image_height_q <= HGT_W'(480);
      kernel_q[0]    <= '0;
      kernel_q[1]    <= KROW_W'(256);
      kernel_q[2]    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:   image_width_q  <= cfg_wdata_i[WID_W-1:0];
        REG_IMAGE_HEIGHT:  image_height_q <= cfg_wdata_i[HGT_W-1:0];
        REG_KERNEL_ABOVE:  kernel_q[0]    <= cfg_wdata_i;
        REG_KERNEL_CENTER: kernel_q[1]    <= cfg_wdata_i;
        REG_KERNEL_BELOW:  kernel_q[2]    <= cfg_wdata_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // effective frame size: zero acts as one, width capped at the line store
  logic [WID_W-1:0] width_eff;
  logic [HGT_W-1:0] height_eff;

  always_comb begin
    if (image_width_q == '0) begin
      width_eff = WID_W'(1);
    end else if (image_width_q > WID_W'(W_CAP)) begin
      width_eff = WID_W'(W_CAP);
    end else begin
      width_eff = image_width_q;
    end
    height_eff = (image_height_q == '0) ? HGT_W'(1) : image_height_q;
  end

  logic    accept;
  fq_ctl_t fq_ctl;
  win_t    fq_entry, bq_entry;
  logic    bq_valid, bq_pop;

  assign accept = push && !full;

  rcc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .kind_i   (kind_i),
    .pixel_i  ({pixel_blue_i, pixel_green_i, pixel_red_i}),
    .width_i  (width_eff),
    .height_i (height_eff),
    .ctl_o    (fq_ctl),
    .entry_o  (fq_entry)
  );

  rcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fq_ctl),
    .entry_i (fq_entry),
    .pop_i   (bq_pop),
    .full_o  (full),
    .valid_o (bq_valid),
    .entry_o (bq_entry)
  );

  rcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (bq_valid),
    .q_entry_i   (bq_entry),
    .q_pop_o     (bq_pop),
    .kernel_i    (kernel_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .frame_end_o (frame_end_o)
  );

endmodule

>>> hdl/rcc_ram.sv
// ----------------------------------------------------------------------------
// rcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

>>> hdl/rcc_front.sv
// ----------------------------------------------------------------------------
// rcc_front
// Position tracking, classification, line store and 3x3 window.
// ----------------------------------------------------------------------------
module rcc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      kind_i,
  input  logic [rcc_pkg::PIX_W-1:0] pixel_i,
  input  logic [rcc_pkg::WID_W-1:0] width_i,
  input  logic [rcc_pkg::HGT_W-1:0] height_i,
  output rcc_pkg::fq_ctl_t          ctl_o,
  output rcc_pkg::win_t             entry_o
);
  import rcc_pkg::*;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [CMP_W-1:0] col_x, w_x, ocol;
  logic [ROW_W-1:0] h_x, row_off, orow;
  logic             col0, col_ok, row_ok, res, last, wrap;
  logic [TAPS-1:0]  rmask, cmask;
  logic [NTAP-1:0]  mask;
  logic [PIX_W-1:0] px;

  // classify the incoming item against the output position it completes
  always_comb begin
    col_x   = CMP_W'(col_q);
    w_x     = CMP_W'(width_i);
    h_x     = ROW_W'(height_i);
    col0    = (col_q == '0);
    ocol    = col0 ? (w_x - 1'b1) : (col_x - 1'b1);
    col_ok  = col0 || (col_x <= w_x);
    row_off = col0 ? ROW_W'(2) : ROW_W'(1);
    orow    = row_q - row_off;
    row_ok  = (row_q >= row_off) && (orow < h_x);
    res     = col_ok && row_ok;
    last    = (orow == h_x - 1'b1) && (ocol == w_x - 1'b1);
    rmask   = {orow != h_x - 1'b1, 1'b1, orow != '0};
    cmask   = {ocol != w_x - 1'b1, 1'b1, ocol != '0};
    for (int r = 0; r < TAPS; r++) begin
      for (int c = 0; c < TAPS; c++) begin
        mask[r*TAPS+c] = rmask[r] & cmask[c];
      end
    end
    wrap = (col_x + 1'b1) >= w_x;
    px   = kind_i ? '0 : pixel_i;

    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (res && last) begin
        col_d = '0;
        row_d = '0;
      end else if (wrap) begin
        col_d = '0;
        row_d = row_q + 1'b1;
        // ran past the drain rows: start a fresh frame
        if (!res && (row_q > h_x)) begin
          row_d = '0;
        end
      end else begin
        col_d = COL_W'(col_x + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line store read is back, window shifts
  logic                  s1_valid_q, s1_res_q, s1_last_q, fwd_q;
  logic [PIX_W-1:0]      s1_px_q;
  logic [NTAP-1:0]       s1_mask_q;
  logic [COL_W-1:0]      s1_addr_q;
  logic [LINE_W-1:0]     rd_data, line, wr_data, fwd_data_q;
  logic [PIX_W-1:0]      up, lo;
  logic [NTAP-1:0][PIX_W-1:0] win_q, win_d;

  rcc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .re_i    (accept_i),
    .raddr_i (col_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    line    = fwd_q ? fwd_data_q : rd_data;
    up      = line[LINE_W-1:PIX_W];
    lo      = line[PIX_W-1:0];
    wr_data = {lo, s1_px_q};
    for (int r = 0; r < TAPS; r++) begin
      win_d[r*TAPS]   = win_q[r*TAPS+1];
      win_d[r*TAPS+1] = win_q[r*TAPS+2];
    end
    win_d[TAPS-1]   = up;
    win_d[2*TAPS-1] = lo;
    win_d[NTAP-1]   = s1_px_q;
    for (int i = 0; i < NTAP; i++) begin
      entry_o.px[i] = s1_mask_q[i] ? win_d[i] : '0;
    end
    entry_o.last  = s1_last_q;
    ctl_o.reserve = accept_i && res;
    ctl_o.push    = s1_valid_q && s1_res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
      fwd_q      <= 1'b0;
      win_q      <= '0;
    end else begin
      s1_valid_q <= accept_i;
      s1_res_q   <= accept_i && res;
      // same address read while the previous item writes it (one-pixel rows)
      fwd_q      <= accept_i && s1_valid_q && (col_q == s1_addr_q);
      if (s1_valid_q) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data;
    if (accept_i) begin
      s1_px_q   <= px;
      s1_mask_q <= mask;
      s1_last_q <= last;
      s1_addr_q <= col_q;
    end
  end

endmodule

>>> hdl/rcc_queue.sv
// ----------------------------------------------------------------------------
// rcc_queue
// Short window queue between front and back, with slot reservation.
// ----------------------------------------------------------------------------
`include "rgb_conv3x3_clamp_top_defines.svh"

module rcc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rcc_pkg::fq_ctl_t ctl_i,
  input  rcc_pkg::win_t    entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output rcc_pkg::win_t    entry_o
);
  import rcc_pkg::*;

  localparam int CNT_W = $clog2(MID_DEPTH + 1);
  localparam int PTR_W = $clog2(MID_DEPTH);

  win_t             mem_q [MID_DEPTH];
  logic [CNT_W-1:0] cnt_q, rsv_q;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;

  // slot is reserved at input transfer, filled in the cycle after it
  assign full_o  = (rsv_q == CNT_W'(MID_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rsv_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNT_W'(ctl_i.push) - CNT_W'(pop_i);
      rsv_q <= rsv_q + CNT_W'(ctl_i.reserve) - CNT_W'(pop_i);
      if (ctl_i.push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(MID_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(MID_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `RCC_ASSERT(a_cnt_within_rsv, cnt_q <= rsv_q, "queue holds more than was reserved")
  `RCC_ASSERT(a_push_room, ctl_i.push |-> (cnt_q < CNT_W'(MID_DEPTH)), "push into full queue")
  `RCC_ASSERT_NEXT(a_rsv_held, ctl_i.reserve && !pop_i, rsv_q != '0, "reservation lost")

endmodule

>>> hdl/rcc_back.sv
// ----------------------------------------------------------------------------
// rcc_back
// Multiply-accumulate, clamp and result queue.
// ----------------------------------------------------------------------------
`include "rgb_conv3x3_clamp_top_defines.svh"

module rcc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  rcc_pkg::win_t              q_entry_i,
  output logic                       q_pop_o,
  input  rcc_pkg::kern_t             kernel_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [rcc_pkg::CHAN_W-1:0] out_red_o,
  output logic [rcc_pkg::CHAN_W-1:0] out_green_o,
  output logic [rcc_pkg::CHAN_W-1:0] out_blue_o,
  output logic                       frame_end_o
);
  import rcc_pkg::*;

  localparam int CR_W  = $clog2(OUT_DEPTH + 1);
  localparam int PTR_W = $clog2(OUT_DEPTH);

  function automatic logic [CHAN_W-1:0] clamp(input logic signed [SUM_W-1:0] s);
    if (s[SUM_W-1]) begin
      return '0;
    end else if (|s[SUM_W-2:FRAC_BITS+CHAN_W]) begin
      return CHAN_W'(CLAMP_TOP);
    end else begin
      return s[FRAC_BITS+CHAN_W-1:FRAC_BITS];
    end
  endfunction

  logic [KX_W-1:0]             kx [TAPS];
  logic signed [COEF_BITS-1:0] tap [NTAP];

  always_comb begin
    for (int r = 0; r < TAPS; r++) begin
      kx[r] = KX_W'(kernel_i[r]);
      for (int k = 0; k < TAPS; k++) begin
        tap[r*TAPS+k] = $signed(kx[r][k*COEF_BITS +: COEF_BITS]);
      end
    end
  end

  // credit covers the pipeline and the result queue
  logic [CR_W-1:0] credit_q;
  logic            issue, out_pop;
  logic [CR_W-1:0] out_cnt_q;

  assign empty_o = (out_cnt_q == '0);
  assign out_pop = pop_i && !empty_o;
  assign issue   = q_valid_i && (credit_q < CR_W'(OUT_DEPTH));
  assign q_pop_o = issue;

  logic                       v1_q, v2_q, last1_q, last2_q;
  logic signed [PROD_W-1:0]   prod_q [NCHAN][NTAP];
  logic signed [ROWSUM_W-1:0] rsum_q [NCHAN][TAPS];
  logic signed [SUM_W-1:0]    total [NCHAN];
  res_t                       res;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      last1_q <= q_entry_i.last;
      for (int ch = 0; ch < NCHAN; ch++) begin
        for (int i = 0; i < NTAP; i++) begin
          prod_q[ch][i] <= $signed({1'b0, q_entry_i.px[i][ch*CHAN_W +: CHAN_W]}) * tap[i];
        end
      end
    end
    if (v1_q) begin
      last2_q <= last1_q;
      for (int ch = 0; ch < NCHAN; ch++) begin
        for (int r = 0; r < TAPS; r++) begin
          rsum_q[ch][r] <= ROWSUM_W'(prod_q[ch][r*TAPS]) + ROWSUM_W'(prod_q[ch][r*TAPS+1])
                         + ROWSUM_W'(prod_q[ch][r*TAPS+2]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCHAN; ch++) begin
      total[ch] = SUM_W'(rsum_q[ch][0]) + SUM_W'(rsum_q[ch][1]) + SUM_W'(rsum_q[ch][2]);
    end
    res.red   = clamp(total[0]);
    res.green = clamp(total[1]);
    res.blue  = clamp(total[2]);
    res.last  = last2_q;
  end

  res_t             out_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      credit_q  <= '0;
      out_cnt_q <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
    end else begin
      v1_q      <= issue;
      v2_q      <= v1_q;
      credit_q  <= credit_q + CR_W'(issue) - CR_W'(out_pop);
      out_cnt_q <= out_cnt_q + CR_W'(v2_q) - CR_W'(out_pop);
      if (v2_q) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (out_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      out_q[wr_ptr_q] <= res;
    end
  end

  assign out_red_o   = out_q[rd_ptr_q].red;
  assign out_green_o = out_q[rd_ptr_q].green;
  assign out_blue_o  = out_q[rd_ptr_q].blue;
  assign frame_end_o = out_q[rd_ptr_q].last;

  `RCC_ASSERT(a_credit_bound, credit_q <= CR_W'(OUT_DEPTH), "credit above result depth")
  `RCC_ASSERT(a_out_room, v2_q |-> (out_cnt_q < CR_W'(OUT_DEPTH)), "result queue overflow")
  `RCC_ASSERT(a_cnt_le_credit, out_cnt_q <= credit_q, "results not covered by credit")

endmodule

>>> sim/conv_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv_filter_checker
// Snoops the register port and both queue channels of the 3x3 RGB filter.
// It recomputes each filtered pixel as input transfers are accepted and
// compares result transfers, in order, against those predictions.
// ----------------------------------------------------------------------------
module conv_filter_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcc_pkg::KROW_W-1:0]    cfg_wdata_i,
  input  logic                          push_i,
  input  logic                          full_i,
  input  logic                          kind_i,
  input  logic [rcc_pkg::CHAN_W-1:0]    pixel_red_i,
  input  logic [rcc_pkg::CHAN_W-1:0]    pixel_green_i,
  input  logic [rcc_pkg::CHAN_W-1:0]    pixel_blue_i,
  input  logic                          empty_i,
  input  logic                          pop_i,
  input  logic [rcc_pkg::CHAN_W-1:0]    out_red_i,
  input  logic [rcc_pkg::CHAN_W-1:0]    out_green_i,
  input  logic [rcc_pkg::CHAN_W-1:0]    out_blue_i,
  input  logic                          frame_end_i,
  output int                            mismatch_cnt_o,
  output int                            pending_o,
  output int                            checked_o
);
  import rcc_pkg::*;

  logic [WID_W-1:0]  width_q;
  logic [HGT_W-1:0]  height_q;
  logic [KROW_W-1:0] kern_q [TAPS];
  logic [PIX_W-1:0]  upper_q [MAX_WIDTH];
  logic [PIX_W-1:0]  lower_q [MAX_WIDTH];
  logic [PIX_W-1:0]  win_q [TAPS][TAPS];
  int unsigned       col_q;
  int unsigned       row_q;
  res_t              filtered_q [$];
  int                mismatch_cnt;
  int                checked_cnt;

  assign mismatch_cnt_o = mismatch_cnt;
  assign pending_o      = filtered_q.size();
  assign checked_o      = checked_cnt;

  function automatic logic [CHAN_W-1:0] clamp_chan(input longint acc);
    longint v;
    if (acc < 0) return '0;
    v = acc >>> FRAC_BITS;
    return (v > CLAMP_TOP) ? CHAN_W'(CLAMP_TOP) : CHAN_W'(v);
  endfunction

  // One accepted item: shift the window, update the line stores and, if the
  // window centre lies inside the frame, produce the filtered pixel.
  function automatic bit filter_step(input logic is_drain, input logic [PIX_W-1:0] pix_in,
                                     output res_t res);
    int          w, h, orow, ocol, rr, cc, r, c, ch;
    int unsigned col, idx;
    logic [PIX_W-1:0] px, up, lo;
    logic [PIX_W-1:0] nb [TAPS][TAPS];
    longint      acc [NCHAN];
    longint      tap;
    w   = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q));
    h   = (height_q == 0) ? 1 : int'(height_q);
    px  = is_drain ? '0 : pix_in;
    col = col_q;
    res = '0;
    if (col == 0) begin
      // centre is the last pixel of the row two above the input row; right column is padding
      orow = int'(row_q) - 2;
      ocol = w - 1;
      for (r = 0; r < TAPS; r++) begin
        nb[r][0] = win_q[r][1];
        nb[r][1] = win_q[r][2];
        nb[r][2] = '0;
      end
    end else begin
      orow = int'(row_q) - 1;
      ocol = int'(col) - 1;
    end
    idx = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
    up  = upper_q[idx];
    lo  = lower_q[idx];
    for (r = 0; r < TAPS; r++) begin
      win_q[r][0] = win_q[r][1];
      win_q[r][1] = win_q[r][2];
    end
    win_q[0][2]  = up;
    win_q[1][2]  = lo;
    win_q[2][2]  = px;
    upper_q[idx] = lo;
    lower_q[idx] = px;
    if (col != 0) nb = win_q;

    if (orow >= 0 && orow < h && ocol >= 0 && ocol < w) begin
      for (ch = 0; ch < NCHAN; ch++) acc[ch] = 0;
      for (r = 0; r < TAPS; r++) begin
        rr = orow + r - 1;
        if (rr >= 0 && rr < h) begin
          for (c = 0; c < TAPS; c++) begin
            cc = ocol + c - 1;
            if (cc >= 0 && cc < w) begin
              tap = longint'($signed(kern_q[r][c*COEF_BITS +: COEF_BITS]));
              for (ch = 0; ch < NCHAN; ch++)
                acc[ch] += longint'(nb[r][c][ch*CHAN_W +: CHAN_W]) * tap;
            end
          end
        end
      end
      res.red   = clamp_chan(acc[0]);
      res.green = clamp_chan(acc[1]);
      res.blue  = clamp_chan(acc[2]);
      res.last  = (orow == h - 1) && (ocol == w - 1);
      if (res.last) begin
        col_q = 0;
        row_q = 0;
      end else if (col + 1 >= w) begin
        col_q = 0;
        row_q++;
      end else begin
        col_q = col + 1;
      end
      return 1'b1;
    end

    if (col + 1 >= w) begin
      col_q = 0;
      row_q++;
      if (row_q > h + 1) row_q = 0;
    end else begin
      col_q = col + 1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    res_t predicted, wanted, seen;
    int   i, r, c;
    if (!rst_ni) begin
      width_q  = WID_W'(640);
      height_q = HGT_W'(480);
      kern_q[0] = '0;
      kern_q[1] = KROW_W'(256);
      kern_q[2] = '0;
      for (i = 0; i < MAX_WIDTH; i++) begin
        upper_q[i] = '0;
        lower_q[i] = '0;
      end
      for (r = 0; r < TAPS; r++)
        for (c = 0; c < TAPS; c++) win_q[r][c] = '0;
      col_q = 0;
      row_q = 0;
      filtered_q.delete();
      mismatch_cnt = 0;
      checked_cnt  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMAGE_WIDTH:   width_q   = cfg_wdata_i[WID_W-1:0];
          REG_IMAGE_HEIGHT:  height_q  = cfg_wdata_i[HGT_W-1:0];
          REG_KERNEL_ABOVE:  kern_q[0] = cfg_wdata_i;
          REG_KERNEL_CENTER: kern_q[1] = cfg_wdata_i;
          REG_KERNEL_BELOW:  kern_q[2] = cfg_wdata_i;
          default: ;
        endcase
      end

      if (push_i && !full_i) begin
        if (filter_step(kind_i, {pixel_blue_i, pixel_green_i, pixel_red_i}, predicted))
          filtered_q.push_back(predicted);
      end

      if (pop_i && !empty_i) begin
        seen = '{red: out_red_i, green: out_green_i, blue: out_blue_i, last: frame_end_i};
        checked_cnt++;
        if (filtered_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result, expected none, actual r=%0d g=%0d b=%0d end=%0b",
                   $time, seen.red, seen.green, seen.blue, seen.last);
        end else begin
          wanted = filtered_q.pop_front();
          if (seen !== wanted) begin
            mismatch_cnt++;
            $display("%0t: mismatch, expected r=%0d g=%0d b=%0d end=%0b,",
                     $time, wanted.red, wanted.green, wanted.blue, wanted.last,
                     " actual r=%0d g=%0d b=%0d end=%0b",
                     seen.red, seen.green, seen.blue, seen.last);
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the zero-padded 3x3 RGB filter. Frames of random
// pixels at many sizes and kernels are pushed through with random idling on
// both queue sides; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import rcc_pkg::*;

  localparam int          ITEMS_GOAL = 300;     // random-part input transfers
  localparam int          WIDE_TAIL  = 41;      // drains after the widest row
  localparam int          TAIL_WAIT  = 16;      // lets the pipeline run dry, with a margin
  localparam int unsigned LIMIT      = 400000;  // watchdog, in clock cycles

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  logic                 clk_i;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [KROW_W-1:0]    cfg_wdata = '0;
  logic                 push      = 1'b0;
  logic                 full;
  logic                 kind      = KIND_PIXEL;
  logic [CHAN_W-1:0]    pix_red   = '0;
  logic [CHAN_W-1:0]    pix_green = '0;
  logic [CHAN_W-1:0]    pix_blue  = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  logic [CHAN_W-1:0]    res_red, res_green, res_blue;
  logic                 res_end;

  int          mismatches, pending, checked;
  int          items_sent   = 0;
  int          settings_cnt = 0;
  int          cur_w, cur_h;          // effective frame size now in force
  bit          steady       = 1'b0;   // set: neither side idles
  int unsigned cycle_cnt    = 0;

  rgb_conv3x3_clamp_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .push          (push),
    .full          (full),
    .kind_i        (kind),
    .pixel_red_i   (pix_red),
    .pixel_green_i (pix_green),
    .pixel_blue_i  (pix_blue),
    .empty         (empty),
    .pop           (pop),
    .out_red_o     (res_red),
    .out_green_o   (res_green),
    .out_blue_o    (res_blue),
    .frame_end_o   (res_end)
  );

  conv_filter_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .push_i         (push),
    .full_i         (full),
    .kind_i         (kind),
    .pixel_red_i    (pix_red),
    .pixel_green_i  (pix_green),
    .pixel_blue_i   (pix_blue),
    .empty_i        (empty),
    .pop_i          (pop),
    .out_red_i      (res_red),
    .out_green_i    (res_green),
    .out_blue_i     (res_blue),
    .frame_end_i    (res_end),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("[rgb_conv3x3_clamp_top] ERROR");
      $finish;
    end
  end

  // Result side: pop is held off about 31 percent of the time, except in the
  // steady stretch. One assignment per edge, so no glitch on a held pop.
  always @(posedge clk_i) pop <= steady || ($urandom_range(0, 99) >= 31);

  // One input transfer. Random idle cycles go in front of it; push then
  // stays high until the block takes the item (full low at the edge).
  task automatic send_item(input logic is_drain, input logic [PIX_W-1:0] px);
    if (!steady) begin
      while ($urandom_range(0, 99) < 31) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push      <= 1'b1;
    kind      <= is_drain;
    pix_red   <= px[0*CHAN_W +: CHAN_W];
    pix_green <= px[1*CHAN_W +: CHAN_W];
    pix_blue  <= px[2*CHAN_W +: CHAN_W];
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  // Wait until every predicted result has transferred, then let the pipeline
  // run dry: an item that yields no result may still be in flight.
  task automatic settle();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [KROW_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  // Writes all five registers back to back once the block is idle. Width and
  // height carry junk above their register width, which must be dropped.
  task automatic load_settings(input logic [WID_W-1:0] w, input logic [HGT_W-1:0] h,
                               input logic [KROW_W-1:0] ka, input logic [KROW_W-1:0] kc,
                               input logic [KROW_W-1:0] kb);
    logic [KROW_W-1:0] junk;
    settle();
    junk = KROW_W'({$urandom, $urandom});
    write_reg(REG_IMAGE_WIDTH,   {junk[KROW_W-1:WID_W], w});
    write_reg(REG_IMAGE_HEIGHT,  {junk[KROW_W-1:HGT_W], h});
    write_reg(REG_KERNEL_ABOVE,  ka);
    write_reg(REG_KERNEL_CENTER, kc);
    write_reg(REG_KERNEL_BELOW,  kb);
    cfg_we <= 1'b0;
    cur_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : int'(w));
    cur_h = (h == 0) ? 1 : int'(h);
    settings_cnt++;
  endtask

  // Mostly mild taps (about -0.16..0.31 each) so that sums often land inside
  // 0..255; now and then a fully random row that drives the clamp.
  function automatic logic [KROW_W-1:0] rand_kernel_row();
    logic [KROW_W-1:0] row;
    int                k;
    if ($urandom_range(0, 3) == 0) begin
      row = KROW_W'({$urandom, $urandom});
    end else begin
      for (k = 0; k < TAPS; k++)
        row[k*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom_range(0, 120) - 40);
    end
    return row;
  endfunction

  // A frame in raster order followed by width+1 drain transfers. A broken
  // frame is cut short, has one pixel/drain swapped, or runs on with extra
  // drains that spill into the next frame.
  task automatic run_frame(input bit broken);
    int n_pix, n_all, cut, flip, i;
    bit is_drain;
    n_pix = cur_w * cur_h;
    n_all = n_pix + cur_w + 1;
    cut   = n_all;
    flip  = -1;
    if (broken) begin
      case ($urandom_range(0, 2))
        0:       cut  = $urandom_range(1, n_all - 1);
        1:       flip = $urandom_range(0, n_all - 1);
        default: cut  = n_all + $urandom_range(1, 5);
      endcase
    end
    for (i = 0; i < cut; i++) begin
      is_drain = (i >= n_pix);
      if (i == flip) is_drain = !is_drain;
      // drain items still carry random channels; the block must ignore them
      send_item(is_drain ? KIND_DRAIN : KIND_PIXEL, PIX_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int               base, sel, nframes, i;
    logic [WID_W-1:0] w;
    logic [HGT_W-1:0] h;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // 2x2 with every tap at the largest positive value: saturates high.
    // A drain sits in a pixel slot and a pixel in a drain slot.
    load_settings(WID_W'(2), HGT_W'(2), {TAPS{16'h7FFF}}, {TAPS{16'h7FFF}},
                  {TAPS{16'h7FFF}});
    send_item(KIND_PIXEL, 24'hFFFFFF);
    send_item(KIND_DRAIN, 24'hA5C35A);
    send_item(KIND_PIXEL, 24'h000000);
    send_item(KIND_PIXEL, 24'hFFFFFF);
    send_item(KIND_DRAIN, 24'h000000);
    send_item(KIND_PIXEL, 24'h5A3CA5);
    send_item(KIND_DRAIN, 24'hFFFFFF);

    // Zero width and height behave as 1; most negative taps clamp to 0.
    load_settings('0, '0, {TAPS{16'h8000}}, {TAPS{16'h8000}}, {TAPS{16'h8000}});
    send_item(KIND_PIXEL, 24'hFFFFFF);
    send_item(KIND_DRAIN, 24'hFFFFFF);
    send_item(KIND_DRAIN, 24'h000000);

    // Tallest frame, cut off after two rows and a bit; the height then drops
    // to 1 mid-frame, so the position counters wrap back to a frame start.
    load_settings(WID_W'(3), '1, {16'h0020, 16'h0040, 16'h0020},
                  {16'h0040, 16'h0080, 16'h0040}, {16'h0020, 16'h0040, 16'h0020});
    repeat (7) send_item(KIND_PIXEL, PIX_W'($urandom));
    load_settings(WID_W'(3), HGT_W'(1), {16'h0020, 16'h0040, 16'h0020},
                  {16'h0040, 16'h0080, 16'h0040}, {16'h0020, 16'h0040, 16'h0020});
    repeat (2) send_item(KIND_PIXEL, PIX_W'($urandom));
    run_frame(1'b0);

    // --- random part ---
    // One row at the widest setting (register all ones, caps at MAX_WIDTH),
    // cut short once the first results of the row have come out.
    load_settings('1, HGT_W'(1), rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    for (i = 0; i < MAX_WIDTH + WIDE_TAIL; i++)
      send_item((i < MAX_WIDTH) ? KIND_PIXEL : KIND_DRAIN, PIX_W'($urandom));

    base = items_sent;
    while (items_sent - base < ITEMS_GOAL) begin
      sel = $urandom_range(0, 9);
      h   = HGT_W'($urandom_range(0, 5));
      case (sel)
        0: w = '0;
        1: w = WID_W'(1);
        2: begin
          w = WID_W'($urandom_range(9, 40));
          h = HGT_W'($urandom_range(1, 2));
        end
        default: w = WID_W'($urandom_range(2, 8));
      endcase
      load_settings(w, h, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
      nframes = $urandom_range(1, 3);
      repeat (nframes) begin
        // a stretch in the middle with both sides running flat out
        steady = (items_sent - base >= 80) && (items_sent - base < 200);
        run_frame($urandom_range(0, 99) < 15);
      end
    end
    steady = 1'b0;

    settle();
    $display("Run: %0d input transfers over %0d register settings, %0d results checked",
             items_sent, settings_cnt, checked);
    $display("Widths from 1 to %0d (widest as one cut-short row), zero sizes, broken frames",
             MAX_WIDTH);
    if (mismatches == 0 && pending == 0) begin
      $display("[rgb_conv3x3_clamp_top] OK");
    end else begin
      $display("[rgb_conv3x3_clamp_top] ERROR");
    end
    $finish;
  end

endmodule
